// ===== design/tdsma_pkg.sv =====
`default_nettype none

package tdsma_pkg;

  // ring and field sizes
  localparam int RING_DEPTH = 8;
  localparam int ADC_W      = 10;
  localparam int GAIN_W     = 12;
  localparam int TICK_W     = 16;
  localparam int TDS_W      = 19;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED  = 2'd0,
    CFG_GAIN     = 2'd1,
    CFG_INTERVAL = 2'd2
  } tdsma_cfg_e;

  localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(1210);
  localparam logic [TICK_W-1:0] INTERVAL_RST = TICK_W'(5000);
  localparam logic [TICK_W-1:0] TICK_MAX     = '1;

  // running sum of the whole ring
  localparam int SUM_W = $clog2(((1 << ADC_W) - 1) * RING_DEPTH + 1);

  // scale: sum * 5 * gain * 16 / (1024 * depth) = sum * 5 * gain / 64 / depth
  localparam int GAIN5_W  = GAIN_W + 3;
  localparam int PROD_W   = SUM_W + GAIN5_W;
  localparam int DROP_SH  = 6;
  localparam int Q_W      = PROD_W - DROP_SH;
  localparam int DIV_SH   = $clog2(RING_DEPTH);
  localparam int RECIP_SH = Q_W + DIV_SH;
  localparam int RECIP_W  = Q_W + 1;
  localparam int RPROD_W  = Q_W + RECIP_W;
  // ceil(2^RECIP_SH / depth), exact for every Q_W-bit quotient
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  typedef struct packed {
    logic             took;
    logic [SUM_W-1:0] sum;
  } tdsma_sum_t;

  typedef struct packed {
    logic             took;
    logic [TDS_W-1:0] scaled;
  } tdsma_res_t;

endpackage

`default_nettype wire

// ===== design/tdsma_cell.sv =====
`default_nettype none

module tdsma_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire logic [tdsma_pkg::ADC_W-1:0] d_i,
  output logic      [tdsma_pkg::ADC_W-1:0] q_o
);
  import tdsma_pkg::*;

  logic [ADC_W-1:0] sample_q;

  // one ring slot, takes its left neighbor on each new sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

`default_nettype wire

// ===== design/tdsma_scale.sv =====
`default_nettype none

module tdsma_scale (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire tdsma_pkg::tdsma_sum_t        in_i,
  input  wire logic [tdsma_pkg::GAIN_W-1:0] gain_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output tdsma_pkg::tdsma_res_t             out_o
);
  import tdsma_pkg::*;

  logic               a_valid_q;
  logic               a_took_q;
  logic [PROD_W-1:0]  a_prod_q;
  logic               b_valid_q;
  logic               b_took_q;
  logic [RPROD_W-1:0] b_prod_q;

  logic               a_ready;
  logic               b_ready;
  logic [GAIN5_W-1:0] gain5;
  logic [PROD_W-1:0]  a_prod_d;
  logic [Q_W-1:0]     quot;
  logic [RPROD_W-1:0] b_prod_d;
  logic [RPROD_W-1:0] shifted;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // gain * 5 as shift and add
  assign gain5    = GAIN5_W'(gain_i) + {1'b0, gain_i, 2'b00};
  assign a_prod_d = PROD_W'(in_i.sum) * PROD_W'(gain5);

  // divide by 64 with a shift, then by depth with the reciprocal
  assign quot     = a_prod_q[PROD_W-1:DROP_SH];
  assign b_prod_d = RPROD_W'(quot) * RPROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_took_q <= in_i.took;
      a_prod_q <= a_prod_d;
    end
    if (b_ready && a_valid_q) begin
      b_took_q <= a_took_q;
      b_prod_q <= b_prod_d;
    end
  end

  assign shifted      = b_prod_q >> RECIP_SH;
  assign out_valid_o  = b_valid_q;
  assign out_o.took   = b_took_q;
  assign out_o.scaled = shifted[TDS_W-1:0];

endmodule

`default_nettype wire

// ===== design/tds_sample_moving_average.sv =====
// tds sample moving average
// input channel: one word per millisecond tick, carrying the current 10-bit
// converter reading on adc_reading_i (in_valid_i / in_ready_o)
// output channel: one word per input word, in order: tds_value_o is the held
// scaled ring average (unsigned, 4 fraction bits), sampled_o flags a tick
// that put its reading into the ring (out_valid_o / out_ready_i)
// config channel: cfg_index_i selects enabled (0), gain (1) or
// sample_interval (2); cfg_ready_o is always high, other indexes are dropped
// path: an accepted word passes the ring stage, the multiply by 5*gain, the
// reciprocal multiply for the divide and the output register in turn;
// throughput one word per cycle while the receiver does not stall, set by
// the ring update and one multiplier in each scale stage
// a receiver stall holds the output register; upstream words keep entering
// until every stage is full, then in_ready_o drops
// reset clears the ring, running sum, tick counter and held value to zero and
// loads enabled=0, gain=1210, sample_interval=5000
`default_nettype none

module tds_sample_moving_average (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tdsma_pkg::ADC_W-1:0]      adc_reading_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [tdsma_pkg::TDS_W-1:0]      tds_value_o,
  output logic                                  sampled_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tdsma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tdsma_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tdsma_pkg::*;

  // config registers
  logic              enabled_q;
  logic [GAIN_W-1:0] gain_q;
  logic [TICK_W-1:0] interval_q;

  // front state
  logic [TICK_W-1:0] elapsed_q;
  logic [TICK_W-1:0] elapsed_inc;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_d;
  logic              take;
  logic              accept;

  // ring stage register feeding the scaler
  logic       s1_valid_q;
  tdsma_sum_t s1_q;
  logic       scl_ready;

  // scaler output and output register
  logic             scl_valid;
  tdsma_res_t       scl_res;
  logic             scl_pop;
  logic             out_valid_q;
  logic             sampled_q;
  logic [TDS_W-1:0] tds_q;

  logic [ADC_W-1:0] cell_q [RING_DEPTH];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      gain_q     <= GAIN_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (tdsma_cfg_e'(cfg_index_i))
        CFG_ENABLED:  enabled_q  <= cfg_data_i[0];
        CFG_GAIN:     gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_INTERVAL: interval_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 drains into the scaler; a new word enters when it is empty or draining
  assign in_ready_o = !s1_valid_q || scl_ready;
  assign accept     = in_valid_i && in_ready_o;

  // tick counter saturates, then the sample decision sees the new count
  assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + TICK_W'(1);
  assign take        = enabled_q && (elapsed_inc > interval_q);

  // the oldest sample falls off the end of the chain
  assign sum_d = sum_q - SUM_W'(cell_q[RING_DEPTH-1]) + SUM_W'(adc_reading_i);

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_ring
    tdsma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept && take),
      .d_i     ((i == 0) ? adc_reading_i : cell_q[(i == 0) ? 0 : i - 1]),
      .q_o     (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        elapsed_q <= take ? '0 : elapsed_inc;
        if (take) begin
          sum_q <= sum_d;
        end
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.took <= take;
      s1_q.sum  <= sum_d;
    end
  end

  tdsma_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (scl_ready),
    .in_i        (s1_q),
    .gain_i      (gain_q),
    .out_valid_o (scl_valid),
    .out_ready_i (!out_valid_q || out_ready_i),
    .out_o       (scl_res)
  );

  assign scl_pop = scl_valid && (!out_valid_q || out_ready_i);

  // output register doubles as the held value: a word without a sample
  // repeats whatever the last word carried
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sampled_q   <= 1'b0;
      tds_q       <= '0;
    end else if (scl_pop) begin
      out_valid_q <= 1'b1;
      sampled_q   <= scl_res.took;
      if (scl_res.took) begin
        tds_q <= scl_res.scaled;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tds_value_o = tds_q;
  assign sampled_o   = sampled_q;

  // a sample restarts the tick counter
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && take |=> elapsed_q == '0)
    else $error("tick counter not restarted after sample");

  // the counter holds at its maximum between samples
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !take && elapsed_q == TICK_MAX |=> elapsed_q == TICK_MAX)
    else $error("tick counter wrapped");

  // while disabled the ring sum does not move
  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !enabled_q |=> $stable(sum_q))
    else $error("ring sum changed while disabled");

  // a held output word keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(tds_q))
    else $error("output word lost under stall");

endmodule

`default_nettype wire
